[hdl/tzpr_pkg.sv]
// Shared types, constants and helper functions for the zone-to-point-rays block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package tzpr_pkg;

  localparam int GRID_SIDE_DEF = 8;

  localparam int CNT_W      = 4;   // zone row / column counters
  localparam int SUB_W      = 4;   // sub_ray_count register
  localparam int NM1_W      = 3;   // clamped sub-ray count minus one
  localparam int MAX_SUB    = 8;
  localparam int FOV_W      = 18;
  localparam int RANGE_W    = 16;
  localparam int POS_W      = 24;
  localparam int PT_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SQ_W       = 35;  // x^2 + y^2 + z^2
  localparam int SQRT_STEPS = 18;
  localparam int CW         = 34;  // CORDIC / product word, Q4.30
  localparam int CORDIC_STEPS = 20;
  localparam int Q_FRAC     = 30;
  localparam int HALF_Q30   = 1 << 29;
  localparam int ANG_SHIFT  = 14;
  localparam int STEP_W     = 5;

  localparam logic [FOV_W-1:0]       FOV_LIMIT   = 18'h30000;
  localparam logic signed [CW-1:0]   CORDIC_GAIN = 34'sd652032874;

  // Operand select codes for the shared multiplier.
  localparam logic [STEP_W-1:0] SQ_X   = 5'd0;
  localparam logic [STEP_W-1:0] SQ_Y   = 5'd1;
  localparam logic [STEP_W-1:0] SQ_Z   = 5'd2;
  localparam logic [STEP_W-1:0] SQ_MIN = 5'd3;
  localparam logic [STEP_W-1:0] SQ_MAX = 5'd4;

  localparam logic [STEP_W-1:0] MUL_ALONG = 5'd0;
  localparam logic [STEP_W-1:0] MUL_LEFT  = 5'd1;
  localparam logic [STEP_W-1:0] MUL_UP    = 5'd2;
  localparam logic [STEP_W-1:0] MUL_PL    = 5'd3;
  localparam logic [STEP_W-1:0] MUL_PA    = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUB_RAY_COUNT = 3'd0,
    CFG_FIELD_OF_VIEW = 3'd1,
    CFG_MINIMUM_RANGE = 3'd2,
    CFG_MAXIMUM_RANGE = 3'd3,
    CFG_SENSOR_X      = 3'd4,
    CFG_SENSOR_Y      = 3'd5,
    CFG_SENSOR_Z      = 3'd6,
    CFG_LOOKS_UP      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_VDIV,
    ST_VCOR,
    ST_HDIV,
    ST_HCOR,
    ST_MUL,
    ST_FMT,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQ,
    OP_SQRT,
    OP_DIV,
    OP_COR,
    OP_MUL,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
    logic              vert;
    logic [NM1_W-1:0]  sub_row;
    logic [NM1_W-1:0]  sub_col;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic             emit;
    logic [NM1_W-1:0] n_m1;
  } dp_status_t;

  // Dividend width and iteration count of the angle divider.
  function automatic int div_steps(input int zones);
    return FOV_W + $clog2(8 * zones) + 1;
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [CW:0] v);
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    hi = 35'sd8388607;
    lo = -35'sd8388608;
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

[hdl/tzpr_if.sv]
// Valid/ready channel interfaces for zone points in and ray points out.
// Depends on tzpr_pkg for field widths.
interface tzpr_in_if;
  import tzpr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;
  logic                   point_valid;
  logic                   frame_start;
  modport source (output valid, point_x, point_y, point_z, point_valid, frame_start,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, frame_start,
                output ready);
endinterface

interface tzpr_out_if;
  import tzpr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic                    hit;
  logic                    last_of_zone;
  modport source (output valid, out_x, out_y, out_z, hit, last_of_zone, input ready);
  modport sink (input valid, out_x, out_y, out_z, hit, last_of_zone, output ready);
endinterface

[hdl/tzpr_ctrl.sv]
// Sequencer for the zone-to-point-rays block: steps the datapath through
// squares, square root, angle divide, CORDIC and products. Uses tzpr_pkg.
module tzpr_ctrl #(
  parameter int GRID_SIDE = tzpr_pkg::GRID_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tzpr_pkg::dp_status_t status,
  output tzpr_pkg::dp_cmd_t    cmd
);
  import tzpr_pkg::*;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(div_steps(GRID_SIDE));
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS);
  localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_STEPS);

  ctl_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [NM1_W-1:0]  sr_r, sr_nxt;
  logic [NM1_W-1:0]  sc_r, sc_nxt;

  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    sc_nxt    = sc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_r == SQ_MAX) begin
          sr_nxt    = '0;
          sc_nxt    = '0;
          state_nxt = status.emit ? ST_SQRT : ST_IDLE;
        end
      end
      ST_SQRT: if (cnt_r == SQRT_LAST) state_nxt = ST_VDIV;
      ST_VDIV: if (cnt_r == DIV_LAST) state_nxt = ST_VCOR;
      ST_VCOR: if (cnt_r == COR_LAST) state_nxt = ST_HDIV;
      ST_HDIV: if (cnt_r == DIV_LAST) state_nxt = ST_HCOR;
      ST_HCOR: if (cnt_r == COR_LAST) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == MUL_PA) state_nxt = ST_FMT;
      ST_FMT:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          if (sc_r != status.n_m1) begin
            sc_nxt    = sc_r + 1'b1;
            state_nxt = ST_HDIV;
          end else if (sr_r != status.n_m1) begin
            sc_nxt    = '0;
            sr_nxt    = sr_r + 1'b1;
            state_nxt = ST_VDIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    out_valid    = (state_r == ST_OUT);
    cmd.op       = OP_IDLE;
    cmd.step     = cnt_r;
    cmd.vert     = 1'b0;
    cmd.sub_row  = sr_r;
    cmd.sub_col  = sc_r;
    cmd.last     = (sr_r == status.n_m1) && (sc_r == status.n_m1);
    case (state_r)
      ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      ST_SQ:   cmd.op = OP_SQ;
      ST_SQRT: cmd.op = OP_SQRT;
      ST_VDIV: begin
        cmd.op   = OP_DIV;
        cmd.vert = 1'b1;
      end
      ST_VCOR: begin
        cmd.op   = OP_COR;
        cmd.vert = 1'b1;
      end
      ST_HDIV: cmd.op = OP_DIV;
      ST_HCOR: cmd.op = OP_COR;
      ST_MUL:  cmd.op = OP_MUL;
      ST_FMT:  cmd.op = OP_OUT;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sr_r    <= '0;
      sc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sr_r    <= sr_nxt;
      sc_r    <= sc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SQ && cnt_r == '0))
    else $error("transfer did not start squares");
  a_sub_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (sr_r <= status.n_m1 && sc_r <= status.n_m1))
    else $error("sub-ray index out of range");
  a_zone_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && cmd.last) |=> (state_r == ST_IDLE))
    else $error("zone did not finish after last point");
`endif

endmodule

[hdl/tzpr_datapath.sv]
// Datapath: configuration registers, zone counters, shared multiplier,
// square root, angle divider, CORDIC and output formatting. Uses tzpr_pkg.
module tzpr_datapath #(
  parameter int GRID_SIDE = tzpr_pkg::GRID_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tzpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tzpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [tzpr_pkg::PT_W-1:0]     point_x,
  input  logic signed [tzpr_pkg::PT_W-1:0]     point_y,
  input  logic signed [tzpr_pkg::PT_W-1:0]     point_z,
  input  logic                                 point_valid,
  input  logic                                 frame_start,
  input  tzpr_pkg::dp_cmd_t                    cmd,
  output tzpr_pkg::dp_status_t                 status,
  output logic signed [tzpr_pkg::POS_W-1:0]    out_x,
  output logic signed [tzpr_pkg::POS_W-1:0]    out_y,
  output logic signed [tzpr_pkg::POS_W-1:0]    out_z,
  output logic                                 hit,
  output logic                                 last_of_zone
);
  import tzpr_pkg::*;

  localparam int U_W = $clog2(16 * GRID_SIDE);
  localparam int D_W = U_W + 1;
  localparam int A_W = div_steps(GRID_SIDE);
  localparam logic [CNT_W-1:0] LAST_Z = CNT_W'(GRID_SIDE - 1);

  // configuration
  logic [SUB_W-1:0]        n_cfg_r;
  logic [FOV_W-1:0]        fov_r;
  logic [RANGE_W-1:0]      min_r, max_r;
  logic signed [POS_W-1:0] sx_r, sy_r, sz_r;
  logic                    up_r;

  // zone state and item
  logic [CNT_W-1:0]       zone_row_r, zone_col_r, row_q_r, col_q_r;
  logic [CNT_W-1:0]       row_cur, col_cur;
  logic signed [PT_W-1:0] px_r, py_r, pz_r;
  logic                   pvalid_r, cfg_ok_r;
  logic [NM1_W-1:0]       n_m1_r;

  logic [SQ_W-1:0]  sum_r;
  logic [31:0]      minsq_r, maxsq_r;
  logic [SQ_W-1:0]  sq_rem_r, sq_bit_r;
  logic [SQ_W:0]    sq_res_r, sq_trial;
  logic [PT_W-1:0]  range_r;
  logic             hit_w;

  logic [D_W-1:0]   div_rem_r, div_d_r;
  logic [A_W-1:0]   div_aq_r;
  logic             div_neg_r;
  logic [D_W:0]     div_shift;
  logic             div_ge;

  logic [CNT_W-1:0] zsel;
  logic [NM1_W-1:0] ssel;
  logic [SUB_W-1:0] n_w;
  logic [7:0]       rn;
  logic [U_W-1:0]   t_u, twice, zn, kmag;
  logic             kneg;

  logic signed [CW-1:0]   cx_r, cy_r, cz_r, cv_r, sv_r;
  logic signed [CW-1:0]   cx_nxt, cy_nxt, cz_nxt, dx, dy, ang, at;
  logic [STEP_W-1:0]      ci;
  logic signed [CW-1:0]   along_r, left_r, pu_r, pl_r, pa_r;

  logic signed [CW-1:0]   mul_a, mul_b, rnd;
  logic signed [2*CW-1:0] prod, prod_rnd;
  logic signed [CW:0]     ex, ey, ez;

  logic signed [POS_W-1:0] ox_r, oy_r, oz_r;
  logic                    hit_o_r, last_o_r;

  assign row_cur = frame_start ? '0 : zone_row_r;
  assign col_cur = frame_start ? '0 : zone_col_r;

  assign hit_w = pvalid_r && (sum_r <= SQ_W'(maxsq_r));
  assign status.emit = cfg_ok_r && !(pvalid_r && (sum_r < SQ_W'(minsq_r)));
  assign status.n_m1 = n_m1_r;

  // sub-ray angle numerator: k = 2t + 1 - Z*n, as magnitude and sign
  always_comb begin
    zsel  = cmd.vert ? row_q_r : col_q_r;
    ssel  = cmd.vert ? cmd.sub_row : cmd.sub_col;
    n_w   = {1'b0, n_m1_r} + 4'd1;
    rn    = zsel * n_w;
    t_u   = U_W'(rn + 8'(ssel));
    twice = U_W'({t_u, 1'b1});
    zn    = U_W'(GRID_SIDE * n_w);
    kneg  = twice < zn;
    kmag  = kneg ? (zn - twice) : (twice - zn);
  end

  assign sq_trial  = sq_res_r + {1'b0, sq_bit_r};
  assign div_shift = {div_rem_r, div_aq_r[A_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_d_r};

  // CORDIC rotation step
  always_comb begin
    ci  = cmd.step - 1'b1;
    dx  = cy_r >>> ci;
    dy  = cx_r >>> ci;
    at  = atan_q30(ci);
    ang = signed'(CW'(div_aq_r) << ANG_SHIFT);
    if (!cz_r[CW-1]) begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + at;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ: begin
        case (cmd.step)
          SQ_X: begin
            mul_a = CW'(px_r);
            mul_b = CW'(px_r);
          end
          SQ_Y: begin
            mul_a = CW'(py_r);
            mul_b = CW'(py_r);
          end
          SQ_Z: begin
            mul_a = CW'(pz_r);
            mul_b = CW'(pz_r);
          end
          SQ_MIN: begin
            mul_a = CW'({1'b0, min_r});
            mul_b = CW'({1'b0, min_r});
          end
          SQ_MAX: begin
            mul_a = CW'({1'b0, max_r});
            mul_b = CW'({1'b0, max_r});
          end
          default: ;
        endcase
      end
      OP_DIV: begin
        mul_a = CW'({1'b0, fov_r});
        mul_b = CW'({1'b0, kmag});
      end
      OP_MUL: begin
        case (cmd.step)
          MUL_ALONG: begin
            mul_a = cv_r;
            mul_b = cx_r;
          end
          MUL_LEFT: begin
            mul_a = cv_r;
            mul_b = cy_r;
          end
          MUL_UP: begin
            mul_a = sv_r;
            mul_b = CW'({1'b0, range_r});
          end
          MUL_PL: begin
            mul_a = left_r;
            mul_b = CW'({1'b0, range_r});
          end
          MUL_PA: begin
            mul_a = along_r;
            mul_b = CW'({1'b0, range_r});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = (prod + $signed((2*CW)'(HALF_Q30))) >>> Q_FRAC;
  assign rnd      = prod_rnd[CW-1:0];

  assign ex = up_r ? ((CW+1)'(sx_r) - (CW+1)'(pu_r)) : ((CW+1)'(sx_r) + (CW+1)'(pu_r));
  assign ey = (CW+1)'(sy_r) + (CW+1)'(pl_r);
  assign ez = up_r ? ((CW+1)'(sz_r) + (CW+1)'(pa_r)) : ((CW+1)'(sz_r) - (CW+1)'(pa_r));

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r    <= 4'd1;
      fov_r      <= 18'd51472;
      min_r      <= '0;
      max_r      <= 16'd4000;
      sx_r       <= '0;
      sy_r       <= '0;
      sz_r       <= '0;
      up_r       <= 1'b0;
      zone_row_r <= '0;
      zone_col_r <= '0;
      cfg_ok_r   <= 1'b0;
      n_m1_r     <= '0;
      pvalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SUB_RAY_COUNT: n_cfg_r <= cfg_data[SUB_W-1:0];
          CFG_FIELD_OF_VIEW: fov_r   <= cfg_data[FOV_W-1:0];
          CFG_MINIMUM_RANGE: min_r   <= cfg_data[RANGE_W-1:0];
          CFG_MAXIMUM_RANGE: max_r   <= cfg_data[RANGE_W-1:0];
          CFG_SENSOR_X:      sx_r    <= cfg_data;
          CFG_SENSOR_Y:      sy_r    <= cfg_data;
          CFG_SENSOR_Z:      sz_r    <= cfg_data;
          CFG_LOOKS_UP:      up_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        pvalid_r <= point_valid;
        cfg_ok_r <= (n_cfg_r != '0) && (fov_r != '0) && (fov_r < FOV_LIMIT) &&
                    (max_r > min_r);
        n_m1_r   <= (n_cfg_r > SUB_W'(MAX_SUB)) ? NM1_W'(MAX_SUB - 1) :
                    NM1_W'(n_cfg_r - 4'd1);
        if (col_cur >= LAST_Z) begin
          zone_col_r <= '0;
          zone_row_r <= (row_cur >= LAST_Z) ? '0 : row_cur + 1'b1;
        end else begin
          zone_col_r <= col_cur + 1'b1;
          zone_row_r <= row_cur;
        end
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px_r    <= point_x;
        py_r    <= point_y;
        pz_r    <= point_z;
        row_q_r <= row_cur;
        col_q_r <= col_cur;
      end
      OP_SQ: begin
        case (cmd.step)
          SQ_X:   sum_r   <= prod[SQ_W-1:0];
          SQ_Y:   sum_r   <= sum_r + prod[SQ_W-1:0];
          SQ_Z:   sum_r   <= sum_r + prod[SQ_W-1:0];
          SQ_MIN: minsq_r <= prod[31:0];
          SQ_MAX: maxsq_r <= prod[31:0];
          default: ;
        endcase
      end
      OP_SQRT: begin
        if (cmd.step == '0) begin
          sq_rem_r <= sum_r;
          sq_res_r <= '0;
          sq_bit_r <= {1'b1, {(SQ_W-1){1'b0}}};
        end else begin
          if ({1'b0, sq_rem_r} >= sq_trial) begin
            sq_rem_r <= sq_rem_r - sq_trial[SQ_W-1:0];
            sq_res_r <= (sq_res_r >> 1) + {1'b0, sq_bit_r};
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end
      end
      OP_DIV: begin
        if (cmd.step == '0) begin
          div_aq_r  <= prod[A_W-1:0] + A_W'(zn);
          div_rem_r <= '0;
          div_d_r   <= D_W'({zn, 1'b0});
          div_neg_r <= kneg;
          if (cmd.vert) begin
            range_r <= hit_w ? (sq_res_r[PT_W-1:0] +
                                PT_W'({1'b0, sq_rem_r} > sq_res_r))
                             : {1'b0, max_r};
          end
        end else begin
          div_rem_r <= div_ge ? D_W'(div_shift - {1'b0, div_d_r}) : div_shift[D_W-1:0];
          div_aq_r  <= {div_aq_r[A_W-2:0], div_ge};
        end
      end
      OP_COR: begin
        if (cmd.step == '0) begin
          cx_r <= CORDIC_GAIN;
          cy_r <= '0;
          cz_r <= div_neg_r ? -ang : ang;
        end else begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          if (cmd.vert && cmd.step == STEP_W'(CORDIC_STEPS)) begin
            cv_r <= cx_nxt;
            sv_r <= cy_nxt;
          end
        end
      end
      OP_MUL: begin
        case (cmd.step)
          MUL_ALONG: along_r <= rnd;
          MUL_LEFT:  left_r  <= rnd;
          MUL_UP:    pu_r    <= rnd;
          MUL_PL:    pl_r    <= rnd;
          MUL_PA:    pa_r    <= rnd;
          default: ;
        endcase
      end
      OP_OUT: begin
        ox_r     <= sat24(ex);
        oy_r     <= sat24(ey);
        oz_r     <= sat24(ez);
        hit_o_r  <= hit_w;
        last_o_r <= cmd.last;
      end
      default: ;
    endcase
  end

  assign out_x        = ox_r;
  assign out_y        = oy_r;
  assign out_z        = oz_r;
  assign hit          = hit_o_r;
  assign last_of_zone = last_o_r;

endmodule

[hdl/tof_zone_to_point_rays_top.sv]
// Top level of the time-of-flight zone to point rays block.
// Depends on tzpr_pkg, tzpr_if, tzpr_ctrl and tzpr_datapath.
//
// Usage: zone points enter on in_ch in row-major order, frame_start marking
// zone row 0, column 0. Each kept zone yields n*n ray points on out_ch, n being
// sub_ray_count clamped to 8; last_of_zone flags the final one. A dropped zone,
// or a bad configuration, yields no transfer but still advances the zone
// counters. The user must write registers on cfg_we only while the block is
// idle; the block itself does not enforce this. With GRID_SIDE = 8 there is a
// 25-step angle divider and a 20-step CORDIC. Each point costs a horizontal
// angle divide and CORDIC run plus five more passes through the single shared
// multiplier; a sub-ray row's first point adds a vertical divide and CORDIC run.
// One zone is in work at a time; in_ch.ready is high only when idle.
// The result sits in an output register until taken; a stall on out_ch
// holds the sequencer, nothing is lost.
// Reset (synchronous, active low) restores register defaults, clears the zone
// counters and returns the sequencer to idle.
module tof_zone_to_point_rays_top #(
  parameter int GRID_SIDE = tzpr_pkg::GRID_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tzpr_in_if.sink                         in_ch,
  tzpr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tzpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tzpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tzpr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tzpr_ctrl #(
    .GRID_SIDE(GRID_SIDE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tzpr_datapath #(
    .GRID_SIDE(GRID_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (in_ch.point_x),
    .point_y     (in_ch.point_y),
    .point_z     (in_ch.point_z),
    .point_valid (in_ch.point_valid),
    .frame_start (in_ch.frame_start),
    .cmd         (cmd),
    .status      (status),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y),
    .out_z       (out_ch.out_z),
    .hit         (out_ch.hit),
    .last_of_zone(out_ch.last_of_zone)
  );

endmodule
